// ----- rtl/core/ppc_pkg.sv -----
// Shared types, widths and constants for the planar pose composition pipeline.
`default_nettype none

package ppc_pkg;

  // Field widths
  localparam int POS_W  = 24;
  localparam int HEAD_W = 20;

  // Internal widths: vector in Q.20, angle in 2^-30 rad
  localparam int GUARD_SH = 12;
  localparam int ANG_SH   = 14;
  localparam int DIFF_W   = POS_W + 1;
  localparam int VEC_W    = 40;
  localparam int HSUM_W   = HEAD_W + 1;
  localparam int ANG_W    = 36;

  // Rotator depth and arctangent table
  localparam int CORDIC_STAGES = 16;
  localparam int TABLE_LEN     = 24;
  localparam int STAGE_IDX_W   = $clog2(TABLE_LEN);
  localparam int QUAD_STEPS    = 3;

  // Pipeline: prep, quadrant steps, rotation stages, product, output
  localparam int PIPE_DEPTH = 1 + QUAD_STEPS + CORDIC_STAGES + 2;

  // Gain correction, Q24
  localparam int GAIN_W = 25;
  localparam logic signed [GAIN_W-1:0] GAIN_Q24 = 25'sd10188014;
  localparam int GAIN_SH = 36;

  // Quadrant reduction limits
  localparam logic signed [ANG_W-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;

  // Opcodes
  localparam logic OP_COMPOSE  = 1'b0;
  localparam logic OP_RELATIVE = 1'b1;

  // Item in flight through the rotator
  typedef struct packed {
    logic                     op;
    logic signed [POS_W-1:0]  bx;
    logic signed [POS_W-1:0]  by;
    logic signed [HEAD_W-1:0] head;
    logic                     head_sat;
    logic signed [VEC_W-1:0]  x;
    logic signed [VEC_W-1:0]  y;
    logic signed [ANG_W-1:0]  z;
  } ppc_data_t;

  // Finished result
  typedef struct packed {
    logic signed [POS_W-1:0]  rx;
    logic signed [POS_W-1:0]  ry;
    logic signed [HEAD_W-1:0] rh;
    logic                     sat;
  } ppc_result_t;

  // Truncated atan(2^-i) in units of 2^-30 rad
  function automatic logic signed [ANG_W-1:0] atan_q30(input logic [STAGE_IDX_W-1:0] idx);
    logic signed [ANG_W-1:0] a;
    case (idx)
      5'd0:    a = 36'sh03243F6A8;
      5'd1:    a = 36'sh01DAC6705;
      5'd2:    a = 36'sh00FADBAFC;
      5'd3:    a = 36'sh007F56EA6;
      5'd4:    a = 36'sh003FEAB76;
      5'd5:    a = 36'sh001FFD55B;
      5'd6:    a = 36'sh000FFFAAA;
      5'd7:    a = 36'sh0007FFF55;
      5'd8:    a = 36'sh0003FFFEA;
      5'd9:    a = 36'sh0001FFFFD;
      5'd10:   a = 36'sh0000FFFFF;
      5'd11:   a = 36'sh00007FFFF;
      5'd12:   a = 36'sh00003FFFF;
      5'd13:   a = 36'sh00001FFFF;
      5'd14:   a = 36'sh00000FFFF;
      5'd15:   a = 36'sh000007FFF;
      5'd16:   a = 36'sh000003FFF;
      5'd17:   a = 36'sh000001FFF;
      5'd18:   a = 36'sh000000FFF;
      5'd19:   a = 36'sh0000007FF;
      5'd20:   a = 36'sh0000003FF;
      5'd21:   a = 36'sh0000001FF;
      5'd22:   a = 36'sh0000000FF;
      5'd23:   a = 36'sh00000007F;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ppc_prep.sv -----
// Input stage: forms the vector and angle for the rotator and the saturated heading.
`default_nettype none

module ppc_prep (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic                        op,
  input  wire logic [ppc_pkg::POS_W-1:0]   base_x,
  input  wire logic [ppc_pkg::POS_W-1:0]   base_y,
  input  wire logic [ppc_pkg::HEAD_W-1:0]  base_heading,
  input  wire logic [ppc_pkg::POS_W-1:0]   other_x,
  input  wire logic [ppc_pkg::POS_W-1:0]   other_y,
  input  wire logic [ppc_pkg::HEAD_W-1:0]  other_heading,
  output ppc_pkg::ppc_data_t               dout
);
  import ppc_pkg::*;

  localparam int VEC_PAD = VEC_W - DIFF_W - GUARD_SH;
  localparam int ANG_PAD = ANG_W - HSUM_W - ANG_SH;

  logic signed [DIFF_W-1:0] bx_e, by_e, ox_e, oy_e, vx, vy;
  logic signed [HSUM_W-1:0] bh_e, oh_e, ang, hsum;
  logic signed [HEAD_W-1:0] head_c;
  logic                     hsat;
  ppc_data_t                d_next;

  // Widen fields and select the operation
  always_comb begin
    bx_e = $signed({base_x[POS_W-1], base_x});
    by_e = $signed({base_y[POS_W-1], base_y});
    ox_e = $signed({other_x[POS_W-1], other_x});
    oy_e = $signed({other_y[POS_W-1], other_y});
    bh_e = $signed({base_heading[HEAD_W-1], base_heading});
    oh_e = $signed({other_heading[HEAD_W-1], other_heading});
    if (op == OP_RELATIVE) begin
      vx   = ox_e - bx_e;
      vy   = oy_e - by_e;
      ang  = -bh_e;
      hsum = oh_e - bh_e;
    end else begin
      vx   = ox_e;
      vy   = oy_e;
      ang  = bh_e;
      hsum = oh_e + bh_e;
    end
  end

  // Clamp the heading sum to the field range
  always_comb begin
    hsat   = 1'b0;
    head_c = hsum[HEAD_W-1:0];
    if (hsum[HSUM_W-1] != hsum[HEAD_W-1]) begin
      hsat   = 1'b1;
      head_c = hsum[HSUM_W-1] ? {1'b1, {(HEAD_W-1){1'b0}}} : {1'b0, {(HEAD_W-1){1'b1}}};
    end
  end

  always_comb begin
    d_next.op       = op;
    d_next.bx       = base_x;
    d_next.by       = base_y;
    d_next.head     = head_c;
    d_next.head_sat = hsat;
    d_next.x        = {{VEC_PAD{vx[DIFF_W-1]}}, vx, {GUARD_SH{1'b0}}};
    d_next.y        = {{VEC_PAD{vy[DIFF_W-1]}}, vy, {GUARD_SH{1'b0}}};
    d_next.z        = {{ANG_PAD{ang[HSUM_W-1]}}, ang, {ANG_SH{1'b0}}};
  end

  // Load on advance
  always_ff @(posedge clk) begin
    if (en) begin
      dout <= d_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ppc_quad_cell.sv -----
// One quadrant reduction step: when the angle lies outside [-pi/2, pi/2], folds it by pi and negates the vector.
`default_nettype none

module ppc_quad_cell (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire ppc_pkg::ppc_data_t din,
  output ppc_pkg::ppc_data_t      dout
);
  import ppc_pkg::*;

  ppc_data_t d_next;

  always_comb begin
    d_next = din;
    if (din.z > HALF_PI_Q30) begin
      d_next.z = din.z - PI_Q30;
      d_next.x = -din.x;
      d_next.y = -din.y;
    end else if (din.z < -HALF_PI_Q30) begin
      d_next.z = din.z + PI_Q30;
      d_next.x = -din.x;
      d_next.y = -din.y;
    end
  end

  // Hand to the next cell on advance
  always_ff @(posedge clk) begin
    if (en) begin
      dout <= d_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ppc_cordic_cell.sv -----
// One CORDIC rotation-mode stage with a fixed shift and arctangent.
`default_nettype none

module ppc_cordic_cell (
  input  wire logic                            clk,
  input  wire logic                            en,
  input  wire logic [ppc_pkg::STAGE_IDX_W-1:0] idx,
  input  wire ppc_pkg::ppc_data_t              din,
  output ppc_pkg::ppc_data_t                   dout
);
  import ppc_pkg::*;

  logic signed [VEC_W-1:0] dx, dy;
  logic signed [ANG_W-1:0] a;
  ppc_data_t               d_next;

  // Rotate toward a zero residual angle
  always_comb begin
    dx     = din.y >>> idx;
    dy     = din.x >>> idx;
    a      = atan_q30(idx);
    d_next = din;
    if (!din.z[ANG_W-1]) begin
      d_next.x = din.x - dx;
      d_next.y = din.y + dy;
      d_next.z = din.z - a;
    end else begin
      d_next.x = din.x + dx;
      d_next.y = din.y - dy;
      d_next.z = din.z + a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= d_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ppc_gain.sv -----
// Gain correction in split products, rounding, base add and saturation.
`default_nettype none

module ppc_gain (
  input  wire logic               clk,
  input  wire logic               en_mul,
  input  wire logic               en_out,
  input  wire ppc_pkg::ppc_data_t din,
  output ppc_pkg::ppc_result_t    dout
);
  import ppc_pkg::*;

  localparam int LO_W   = 20;
  localparam int HI_W   = VEC_W - LO_W;
  localparam int PH_W   = HI_W + GAIN_W;
  localparam int PL_W   = LO_W + 1 + GAIN_W;
  localparam int FULL_W = PH_W + LO_W + 1;
  localparam int Q_W    = FULL_W - GAIN_SH;
  localparam int SUM_W  = Q_W + 1;
  localparam logic signed [FULL_W-1:0] ROUND = FULL_W'(64'sd1 <<< (GAIN_SH - 1));

  // Product stage registers
  logic signed [PH_W-1:0]   phx, phy;
  logic signed [PL_W-1:0]   plx, ply;
  logic                     op_r, hsat_r;
  logic signed [POS_W-1:0]  bx_r, by_r;
  logic signed [HEAD_W-1:0] head_r;

  logic signed [PH_W-1:0]   phx_c, phy_c;
  logic signed [PL_W-1:0]   plx_c, ply_c;
  logic signed [FULL_W-1:0] fx, fy;
  logic signed [SUM_W-1:0]  sx, sy;
  logic signed [POS_W-1:0]  cx, cy;
  logic                     satx, saty;
  ppc_result_t              res_next;

  // Split each component so no product exceeds 21 x 25 bits
  always_comb begin
    phx_c = $signed(din.x[VEC_W-1:LO_W]) * GAIN_Q24;
    phy_c = $signed(din.y[VEC_W-1:LO_W]) * GAIN_Q24;
    plx_c = $signed({1'b0, din.x[LO_W-1:0]}) * GAIN_Q24;
    ply_c = $signed({1'b0, din.y[LO_W-1:0]}) * GAIN_Q24;
  end

  always_ff @(posedge clk) begin
    if (en_mul) begin
      phx    <= phx_c;
      phy    <= phy_c;
      plx    <= plx_c;
      ply    <= ply_c;
      op_r   <= din.op;
      bx_r   <= din.bx;
      by_r   <= din.by;
      head_r <= din.head;
      hsat_r <= din.head_sat;
    end
  end

  // Recombine, round half up, add the base in compose mode
  always_comb begin
    fx = $signed({phx[PH_W-1], phx, {LO_W{1'b0}}})
         + $signed({{(FULL_W-PL_W){plx[PL_W-1]}}, plx}) + ROUND;
    fy = $signed({phy[PH_W-1], phy, {LO_W{1'b0}}})
         + $signed({{(FULL_W-PL_W){ply[PL_W-1]}}, ply}) + ROUND;
    sx = $signed({fx[FULL_W-1], fx[FULL_W-1:GAIN_SH]});
    sy = $signed({fy[FULL_W-1], fy[FULL_W-1:GAIN_SH]});
    if (op_r == OP_COMPOSE) begin
      sx = sx + $signed({{(SUM_W-POS_W){bx_r[POS_W-1]}}, bx_r});
      sy = sy + $signed({{(SUM_W-POS_W){by_r[POS_W-1]}}, by_r});
    end
  end

  // Clamp positions to the field range
  always_comb begin
    satx = 1'b0;
    saty = 1'b0;
    cx   = sx[POS_W-1:0];
    cy   = sy[POS_W-1:0];
    if (sx[SUM_W-1:POS_W-1] != {(SUM_W-POS_W+1){sx[SUM_W-1]}}) begin
      satx = 1'b1;
      cx   = sx[SUM_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end
    if (sy[SUM_W-1:POS_W-1] != {(SUM_W-POS_W+1){sy[SUM_W-1]}}) begin
      saty = 1'b1;
      cy   = sy[SUM_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end
    res_next.rx  = cx;
    res_next.ry  = cy;
    res_next.rh  = head_r;
    res_next.sat = satx | saty | hsat_r;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (en_out) begin
      dout <= res_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/planar_pose_compose.sv -----
// Top level: SE(2) pose composition and relative pose over a chain of CORDIC cells.
//
// Usage:
//   Slave channel s_*: one pose pair per transfer; s_tuser is the opcode
//   (0 compose base with offset, 1 relative pose of the second versus the base).
//   Master channel m_*: one result per input transfer, in order; m_tuser flags
//   that a result field was clamped to its range.
//   An input transfer passes through one prep stage, three quadrant reduction
//   cells, sixteen rotation cells, one gain product stage and the output
//   register before m_tvalid. Throughput is one transfer per cycle while the
//   receiver accepts results; every cell takes a new item each cycle it advances.
//   Each cell has a valid bit and advances whenever it is empty or its neighbor
//   advances, so when the receiver stalls, bubbles in the chain are squeezed out
//   and s_tready drops only once every cell holds an item.
//   Reset clears all valid bits; payload registers are left as they are.
`default_nettype none

module planar_pose_compose (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output      logic          s_tready,
  // base_x, base_y, base_heading, other_x, other_y, other_heading (from bit 0 up)
  input  wire logic [135:0]  s_tdata,
  // opcode
  input  wire logic [0:0]    s_tuser,
  output      logic          m_tvalid,
  input  wire logic          m_tready,
  // result_x, result_y, result_heading, 4 bits zero fill (from bit 0 up)
  output      logic [71:0]   m_tdata,
  // saturated
  output      logic [0:0]    m_tuser
);
  import ppc_pkg::*;

  localparam int Q0 = 1;
  localparam int C0 = Q0 + QUAD_STEPS;
  localparam int GM = C0 + CORDIC_STAGES;
  localparam int GO = GM + 1;

  logic [PIPE_DEPTH-1:0] vld;
  logic [PIPE_DEPTH:0]   en;
  ppc_data_t             stg [0:GM-1];
  ppc_result_t           res;

  // Advance chain from the output back to the input
  always_comb begin
    en[PIPE_DEPTH] = m_tready;
    for (int k = PIPE_DEPTH - 1; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign s_tready = en[0];

  // Valid bits move with their items
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < PIPE_DEPTH; k++) begin
        if (en[k]) begin
          vld[k] <= (k == 0) ? s_tvalid : vld[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  ppc_prep u_prep (
    .clk           (clk),
    .en            (en[0]),
    .op            (s_tuser[0]),
    .base_x        (s_tdata[23:0]),
    .base_y        (s_tdata[47:24]),
    .base_heading  (s_tdata[67:48]),
    .other_x       (s_tdata[91:68]),
    .other_y       (s_tdata[115:92]),
    .other_heading (s_tdata[135:116]),
    .dout          (stg[0])
  );

  for (genvar q = 0; q < QUAD_STEPS; q++) begin : g_quad
    ppc_quad_cell u_quad (
      .clk  (clk),
      .en   (en[Q0+q]),
      .din  (stg[Q0+q-1]),
      .dout (stg[Q0+q])
    );
  end

  for (genvar c = 0; c < CORDIC_STAGES; c++) begin : g_cordic
    ppc_cordic_cell u_cell (
      .clk  (clk),
      .en   (en[C0+c]),
      .idx  (STAGE_IDX_W'(c)),
      .din  (stg[C0+c-1]),
      .dout (stg[C0+c])
    );
  end

  ppc_gain u_gain (
    .clk    (clk),
    .en_mul (en[GM]),
    .en_out (en[GO]),
    .din    (stg[GM-1]),
    .dout   (res)
  );

  // Drive the master channel from the output register
  assign m_tvalid = vld[GO];
  assign m_tdata  = {4'b0000, res.rh, res.ry, res.rx};
  assign m_tuser  = res.sat;

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking bench for the planar pose composition pipeline: streamed pose pairs, predicted results.
`timescale 1ns / 100ps

module tb_top;

  // Q15.8 position and Q3.16 heading limits
  localparam longint POS_MIN_L  = -(longint'(1) <<< (ppc_pkg::POS_W - 1));
  localparam longint POS_MAX_L  = (longint'(1) <<< (ppc_pkg::POS_W - 1)) - 1;
  localparam longint HEAD_MIN_L = -(longint'(1) <<< (ppc_pkg::HEAD_W - 1));
  localparam longint HEAD_MAX_L = (longint'(1) <<< (ppc_pkg::HEAD_W - 1)) - 1;

  // pi/2 and pi in Q3.16, rounded to the nearest code
  localparam longint QUARTER_TURN_Q16 = 102944;
  localparam longint HALF_TURN_Q16    = 205887;

  localparam int RANDOM_PAIRS = 1330;
  // Pressure hold-off of the receiver, and the point in the run where it starts
  localparam int HOLDOFF_CYCLES = 300;
  localparam int HOLDOFF_AFTER  = 400;
  // Longest quiet stretch of a correct run: hold-off, a sender gap and the pipeline
  // latency; the limit allows a wide margin over it.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 40;

  typedef enum int {
    RX_STREAM,
    RX_COIN,
    RX_MOSTLY,
    RX_EVERY_THIRD
  } rx_pattern_t;

  typedef struct {
    logic                              op;
    logic signed [ppc_pkg::POS_W-1:0]  bx;
    logic signed [ppc_pkg::POS_W-1:0]  by;
    logic signed [ppc_pkg::HEAD_W-1:0] bh;
    logic signed [ppc_pkg::POS_W-1:0]  ox;
    logic signed [ppc_pkg::POS_W-1:0]  oy;
    logic signed [ppc_pkg::HEAD_W-1:0] oh;
  } pose_pair_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [135:0] s_tdata = '0;
  logic [0:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [71:0]  m_tdata;
  logic [0:0]   m_tuser;

  // Truncated atan(2^-i) in units of 2^-30 rad
  longint atan_steps [0:23] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
  };

  pose_pair_t            pose_queue [$];
  ppc_pkg::ppc_result_t  expected_results [$];

  pose_pair_t  on_bus;
  int          burst_left;
  int          gap_left;
  logic        next_valid;
  int          pairs_sent;
  int          relative_sent;
  int          input_stall_cycles;

  rx_pattern_t rx_pattern;
  int          pattern_left;
  int          holdoff_left;
  logic        holdoff_done;
  logic        next_ready;
  int          results_seen;
  int          clamped_seen;
  ppc_pkg::ppc_result_t want;

  int          idle_cycles;
  int          errors;

  planar_pose_compose dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Expected result of one pose pair: quadrant fold, CORDIC rotation, gain, saturation
  function automatic ppc_pkg::ppc_result_t predict_pose(pose_pair_t p);
    longint vx, vy, z, dx, dy, rx, ry, rh, crx, cry, crh;
    ppc_pkg::ppc_result_t r;
    if (p.op == ppc_pkg::OP_COMPOSE) begin
      vx = p.ox;
      vy = p.oy;
      z  = p.bh;
    end else begin
      vx = longint'(p.ox) - longint'(p.bx);
      vy = longint'(p.oy) - longint'(p.by);
      z  = -longint'(p.bh);
    end
    vx = vx * (longint'(1) <<< ppc_pkg::GUARD_SH);
    vy = vy * (longint'(1) <<< ppc_pkg::GUARD_SH);
    z  = z * (longint'(1) <<< ppc_pkg::ANG_SH);
    // Fold the angle into [-pi/2, pi/2], flipping the vector each time
    for (int k = 0; k < ppc_pkg::QUAD_STEPS; k++) begin
      if (z > longint'(ppc_pkg::HALF_PI_Q30)) begin
        z  = z - longint'(ppc_pkg::PI_Q30);
        vx = -vx;
        vy = -vy;
      end else if (z < -longint'(ppc_pkg::HALF_PI_Q30)) begin
        z  = z + longint'(ppc_pkg::PI_Q30);
        vx = -vx;
        vy = -vy;
      end
    end
    for (int i = 0; i < ppc_pkg::CORDIC_STAGES && i < 24; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      if (z >= 0) begin
        vx = vx - dx;
        vy = vy + dy;
        z  = z - atan_steps[i];
      end else begin
        vx = vx + dx;
        vy = vy - dy;
        z  = z + atan_steps[i];
      end
    end
    // Gain correction and return to Q15.8 with rounding half up
    rx = (vx * longint'(ppc_pkg::GAIN_Q24) + (longint'(1) <<< (ppc_pkg::GAIN_SH - 1)))
         >>> ppc_pkg::GAIN_SH;
    ry = (vy * longint'(ppc_pkg::GAIN_Q24) + (longint'(1) <<< (ppc_pkg::GAIN_SH - 1)))
         >>> ppc_pkg::GAIN_SH;
    if (p.op == ppc_pkg::OP_COMPOSE) begin
      rx = rx + longint'(p.bx);
      ry = ry + longint'(p.by);
      rh = longint'(p.bh) + longint'(p.oh);
    end else begin
      rh = longint'(p.oh) - longint'(p.bh);
    end
    crx = clip(rx, POS_MIN_L, POS_MAX_L);
    cry = clip(ry, POS_MIN_L, POS_MAX_L);
    crh = clip(rh, HEAD_MIN_L, HEAD_MAX_L);
    r.rx  = crx[ppc_pkg::POS_W-1:0];
    r.ry  = cry[ppc_pkg::POS_W-1:0];
    r.rh  = crh[ppc_pkg::HEAD_W-1:0];
    r.sat = (crx != rx) || (cry != ry) || (crh != rh);
    return r;
  endfunction

  function automatic longint rand_bits_signed(int w);
    longint v;
    v = longint'($urandom) & ((longint'(1) <<< w) - 1);
    if (v[w-1]) v = v - (longint'(1) <<< w);
    return v;
  endfunction

  // Mostly moderate magnitudes, some full range, some extremes
  function automatic longint rand_pos();
    int unsigned pick;
    longint span;
    pick = $urandom_range(0, 9);
    if (pick < 3) return rand_bits_signed(ppc_pkg::POS_W);
    if (pick == 3) begin
      case ($urandom_range(0, 3))
        0:       return POS_MIN_L;
        1:       return POS_MAX_L;
        2:       return 0;
        default: return -1;
      endcase
    end
    span = longint'(1) <<< $urandom_range(4, 20);
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Full +-8 rad range, quarter-turn boundaries, and plain angles within +-pi
  function automatic longint rand_head();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 3) return rand_bits_signed(ppc_pkg::HEAD_W);
    if (pick == 3)
      return (longint'($urandom_range(0, 10)) - 5) * QUARTER_TURN_Q16
             + longint'($urandom_range(0, 6)) - 3;
    return longint'($urandom_range(0, 2 * HALF_TURN_Q16)) - HALF_TURN_Q16;
  endfunction

  task automatic add_pair(logic op, longint bx, longint by, longint bh,
                          longint ox, longint oy, longint oh);
    pose_pair_t p;
    p.op = op;
    p.bx = bx;
    p.by = by;
    p.bh = bh;
    p.ox = ox;
    p.oy = oy;
    p.oh = oh;
    pose_queue.push_back(p);
  endtask

  // Sender: bursts of transfers separated by random gaps; hold the item while stalled
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid   <= 1'b0;
      burst_left = $urandom_range(1, 40);
      gap_left   = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(predict_pose(on_bus));
        pairs_sent++;
        if (on_bus.op == ppc_pkg::OP_RELATIVE) relative_sent++;
      end
      if (s_tvalid && !s_tready) begin
        input_stall_cycles++;
      end else begin
        next_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pose_queue.size() > 0) begin
          on_bus = pose_queue.pop_front();
          s_tdata <= {on_bus.oh, on_bus.oy, on_bus.ox, on_bus.bh, on_bus.by, on_bus.bx};
          s_tuser <= on_bus.op;
          next_valid = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
                                                     : $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
        s_tvalid <= next_valid;
      end
    end
  end

  // Receiver: check each result against the oldest expectation, then pick next tready
  always @(posedge clk) begin
    if (rst) begin
      m_tready     <= 1'b0;
      rx_pattern   = RX_STREAM;
      pattern_left = 0;
      holdoff_left = 0;
      holdoff_done = 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result transfer with no pending expectation");
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (want.sat) clamped_seen++;
          if (m_tdata[23:0] !== want.rx) begin
            $error("result_x: expected %0d, got %0d", want.rx, $signed(m_tdata[23:0]));
            errors++;
          end
          if (m_tdata[47:24] !== want.ry) begin
            $error("result_y: expected %0d, got %0d", want.ry, $signed(m_tdata[47:24]));
            errors++;
          end
          if (m_tdata[67:48] !== want.rh) begin
            $error("result_heading: expected %0d, got %0d", want.rh,
                   $signed(m_tdata[67:48]));
            errors++;
          end
          if (m_tdata[71:68] !== 4'b0) begin
            $error("zero fill: expected 0, got %0h", m_tdata[71:68]);
            errors++;
          end
          if (m_tuser[0] !== want.sat) begin
            $error("saturated: expected %0b, got %0b", want.sat, m_tuser[0]);
            errors++;
          end
        end
      end
      // Switch the stall pattern now and then
      if (pattern_left == 0) begin
        rx_pattern   = rx_pattern_t'($urandom_range(0, 3));
        pattern_left = $urandom_range(20, 150);
      end else begin
        pattern_left--;
      end
      // One long hold-off so the pipeline fills and stalls its input
      if (!holdoff_done && results_seen >= HOLDOFF_AFTER) begin
        holdoff_left = HOLDOFF_CYCLES;
        holdoff_done = 1'b1;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        next_ready = 1'b0;
      end else begin
        case (rx_pattern)
          RX_STREAM:      next_ready = 1'b1;
          RX_COIN:        next_ready = $urandom_range(0, 1);
          RX_MOSTLY:      next_ready = ($urandom_range(0, 9) != 0);
          RX_EVERY_THIRD: next_ready = ((pattern_left % 3) == 0);
          default:        next_ready = 1'b1;
        endcase
      end
      m_tready <= next_ready;
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", idle_cycles);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    pairs_sent         = 0;
    relative_sent      = 0;
    input_stall_cycles = 0;
    results_seen       = 0;
    clamped_seen       = 0;
    errors             = 0;
    idle_cycles        = 0;

    // Zero poses in both modes
    add_pair(ppc_pkg::OP_COMPOSE, 0, 0, 0, 0, 0, 0);
    add_pair(ppc_pkg::OP_RELATIVE, 0, 0, 0, 0, 0, 0);
    // Headings just below and just above a quarter turn, and near a half turn
    add_pair(ppc_pkg::OP_COMPOSE, 1000, -1000, QUARTER_TURN_Q16 - 1, 25600, 0, 0);
    add_pair(ppc_pkg::OP_COMPOSE, 1000, -1000, QUARTER_TURN_Q16, 25600, 0, 0);
    add_pair(ppc_pkg::OP_COMPOSE, 0, 0, -QUARTER_TURN_Q16, 0, 25600, 10);
    add_pair(ppc_pkg::OP_RELATIVE, 0, 0, HALF_TURN_Q16, 25600, 25600, -HALF_TURN_Q16);
    add_pair(ppc_pkg::OP_COMPOSE, 0, 0, -HALF_TURN_Q16, -25600, 12800, HALF_TURN_Q16);
    // Extreme headings of about +-8 rad, folded several times
    add_pair(ppc_pkg::OP_COMPOSE, 0, 0, HEAD_MAX_L, 65536, -65536, 0);
    add_pair(ppc_pkg::OP_COMPOSE, 0, 0, HEAD_MIN_L, -65536, 65536, 0);
    add_pair(ppc_pkg::OP_RELATIVE, 0, 0, HEAD_MAX_L, POS_MAX_L, POS_MIN_L, 0);
    // Negating the most negative base heading in relative mode
    add_pair(ppc_pkg::OP_RELATIVE, 0, 0, HEAD_MIN_L, 4096, 4096, 0);
    add_pair(ppc_pkg::OP_RELATIVE, 0, 0, HEAD_MIN_L, 0, 0, HEAD_MAX_L);
    // Heading sum and difference clamped at both ends
    add_pair(ppc_pkg::OP_COMPOSE, 0, 0, HEAD_MAX_L, 0, 0, HEAD_MAX_L);
    add_pair(ppc_pkg::OP_COMPOSE, 0, 0, HEAD_MIN_L, 0, 0, HEAD_MIN_L);
    add_pair(ppc_pkg::OP_RELATIVE, 0, 0, HEAD_MAX_L, 0, 0, HEAD_MIN_L);
    // Position extremes, clamped in compose and in relative mode
    add_pair(ppc_pkg::OP_COMPOSE, POS_MAX_L, POS_MAX_L, 0, POS_MAX_L, POS_MAX_L, 0);
    add_pair(ppc_pkg::OP_COMPOSE, POS_MIN_L, POS_MIN_L, 0, POS_MIN_L, POS_MIN_L, 0);
    add_pair(ppc_pkg::OP_RELATIVE, POS_MIN_L, POS_MAX_L, 0, POS_MAX_L, POS_MIN_L, 0);
    add_pair(ppc_pkg::OP_RELATIVE, POS_MAX_L, POS_MIN_L, 0, POS_MIN_L, POS_MAX_L, 0);
    add_pair(ppc_pkg::OP_COMPOSE, POS_MAX_L, POS_MIN_L, HEAD_MAX_L, POS_MIN_L, POS_MAX_L,
             HEAD_MIN_L);
    add_pair(ppc_pkg::OP_RELATIVE, -1, -1, -1, -1, -1, -1);
    add_pair(ppc_pkg::OP_COMPOSE, -1, -1, -1, -1, -1, -1);

    // Random pairs in both modes
    for (int n = 0; n < RANDOM_PAIRS; n++)
      add_pair($urandom_range(0, 1) ? ppc_pkg::OP_RELATIVE : ppc_pkg::OP_COMPOSE,
               rand_pos(), rand_pos(), rand_head(), rand_pos(), rand_pos(), rand_head());

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Wait for every input transfer, then for every result, then let the pipe settle
    while (pose_queue.size() != 0 || s_tvalid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d pose pairs (%0d relative, %0d compose), %0d results, %0d clamped",
             pairs_sent, relative_sent, pairs_sent - relative_sent, results_seen,
             clamped_seen);
    $display("run: input held off by the pipeline for %0d cycles, %0d mismatches",
             input_stall_cycles, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/ppc_pkg.sv
rtl/core/ppc_prep.sv
rtl/core/ppc_quad_cell.sv
rtl/core/ppc_cordic_cell.sv
rtl/core/ppc_gain.sv
rtl/core/planar_pose_compose.sv
tb/tb_top.sv
